[rtl/ctb_pkg.sv]
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants of the clipped tile blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

  localparam int unsigned TILE_MAX_SIDE_DEF = 8;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned SIDE_W  = 4;
  localparam int unsigned ROWS_W  = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] MODE_TRANSPARENT = 2'd0;
  localparam logic [1:0] MODE_FULL        = 2'd1;
  localparam logic [1:0] MODE_ERASE       = 2'd2;
  localparam logic [1:0] MODE_RESERVED    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 8'd128;
  localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 8'd64;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on;
    logic               last;
  } pix_t;

endpackage

`default_nettype wire

[rtl/ctb_step.sv]
// ----------------------------------------------------------------------------
// ctb_step
// Shared step unit: advances a tile and screen coordinate pair and checks both
// against their limits.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_step (
  input  wire logic                            inc,
  input  wire logic [ctb_pkg::COORD_W-1:0]     t,
  input  wire logic [ctb_pkg::COORD_W-1:0]     s,
  input  wire logic [ctb_pkg::SIDE_W-1:0]      tlim,
  input  wire logic [ctb_pkg::COORD_W-1:0]     slim,
  output logic      [ctb_pkg::COORD_W-1:0]     tn,
  output logic      [ctb_pkg::COORD_W-1:0]     sn,
  output logic                                 ok
);

  always_comb begin
    tn = t + ctb_pkg::COORD_W'(inc);
    sn = s + ctb_pkg::COORD_W'(inc);
    ok = (tn < ctb_pkg::COORD_W'(tlim)) && (sn < slim);
  end

endmodule

`default_nettype wire

[rtl/ctb_seq.sv]
// ----------------------------------------------------------------------------
// ctb_seq
// Sequencer that walks the visible part of a tile through the shared step
// unit and holds back one pixel write until it knows whether it is the last.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_seq #(
  parameter int unsigned TILE_MAX_SIDE = ctb_pkg::TILE_MAX_SIDE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [1:0]                      req_type,
  input  wire logic [ctb_pkg::COORD_W-1:0]     x_pos,
  input  wire logic [ctb_pkg::COORD_W-1:0]     y_pos,
  input  wire logic [7:0]                      tile_size,
  input  wire logic [ctb_pkg::ROWS_W-1:0]      tile_rows,
  input  wire logic [ctb_pkg::COORD_W-1:0]     frame_width,
  input  wire logic [ctb_pkg::COORD_W-1:0]     frame_height,
  input  wire logic                            out_free,
  output logic                                 busy,
  output logic                                 push,
  output ctb_pkg::pix_t                        pix
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHKX  = 3'd1;
  localparam logic [2:0] ST_CHKY  = 3'd2;
  localparam logic [2:0] ST_PIX   = 3'd3;
  localparam logic [2:0] ST_ROW   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0]                     state;
  logic [1:0]                     mode;
  logic [ctb_pkg::COORD_W-1:0]    tx, sx, ty, sy, tx0, sx0;
  logic [ctb_pkg::SIDE_W-1:0]     w, h;
  logic [ctb_pkg::ROWS_W-1:0]     rows;
  logic                           pend_v;
  ctb_pkg::pix_t                  pend;

  logic [ctb_pkg::SIDE_W-1:0]     ws, hs;
  logic                           u_inc;
  logic [ctb_pkg::COORD_W-1:0]    u_t, u_s, u_slim, u_tn, u_sn;
  logic [ctb_pkg::SIDE_W-1:0]     u_tlim;
  logic                           u_ok;
  logic [7:0]                     rowbyte;
  logic                           bit_val, emit_c, can_go;

  ctb_step u_step (
    .inc  (u_inc),
    .t    (u_t),
    .s    (u_s),
    .tlim (u_tlim),
    .slim (u_slim),
    .tn   (u_tn),
    .sn   (u_sn),
    .ok   (u_ok)
  );

  always_comb begin
    ws = {1'b0, tile_size[6:4]} + 4'd1;
    hs = {1'b0, tile_size[2:0]} + 4'd1;
    if (ws > ctb_pkg::SIDE_W'(TILE_MAX_SIDE)) begin
      ws = ctb_pkg::SIDE_W'(TILE_MAX_SIDE);
    end
    if (hs > ctb_pkg::SIDE_W'(TILE_MAX_SIDE)) begin
      hs = ctb_pkg::SIDE_W'(TILE_MAX_SIDE);
    end
  end

  always_comb begin
    u_inc  = 1'b0;
    u_t    = tx;
    u_s    = sx;
    u_tlim = w;
    u_slim = frame_width;
    case (state)
      ST_CHKX: begin
        u_t = tx0;
        u_s = sx0;
      end
      ST_CHKY: begin
        u_t    = ty;
        u_s    = sy;
        u_tlim = h;
        u_slim = frame_height;
      end
      ST_PIX: begin
        u_inc = 1'b1;
      end
      ST_ROW: begin
        u_inc  = 1'b1;
        u_t    = ty;
        u_s    = sy;
        u_tlim = h;
        u_slim = frame_height;
      end
      default: begin
        u_inc = 1'b0;
      end
    endcase
  end

  always_comb begin
    rowbyte = rows[{ty[2:0], 3'b000} +: 8];
    bit_val = rowbyte[~tx[2:0]];
    emit_c  = bit_val || (mode == ctb_pkg::MODE_FULL);
    can_go  = !(emit_c && pend_v) || out_free;
  end

  always_comb begin
    push     = 1'b0;
    pix      = pend;
    pix.last = 1'b0;
    if (state == ST_PIX && emit_c && pend_v && out_free) begin
      push = 1'b1;
    end else if (state == ST_FLUSH && pend_v && out_free) begin
      push     = 1'b1;
      pix.last = 1'b1;
    end
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend_v <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            mode <= req_type;
            w    <= ws;
            h    <= hs;
            rows <= tile_rows;
            tx0  <= x_pos[7] ? (~x_pos + 8'd1) : 8'd0;
            sx0  <= x_pos[7] ? 8'd0 : x_pos;
            tx   <= x_pos[7] ? (~x_pos + 8'd1) : 8'd0;
            sx   <= x_pos[7] ? 8'd0 : x_pos;
            ty   <= y_pos[7] ? (~y_pos + 8'd1) : 8'd0;
            sy   <= y_pos[7] ? 8'd0 : y_pos;
            if (req_type != ctb_pkg::MODE_RESERVED) begin
              state <= ST_CHKX;
            end
          end
        end
        ST_CHKX: begin
          state <= u_ok ? ST_CHKY : ST_FLUSH;
        end
        ST_CHKY: begin
          state <= u_ok ? ST_PIX : ST_FLUSH;
        end
        ST_PIX: begin
          if (can_go) begin
            if (emit_c) begin
              pend_v  <= 1'b1;
              pend.x  <= sx;
              pend.y  <= sy;
              pend.on <= bit_val && (mode != ctb_pkg::MODE_ERASE);
              pend.last <= 1'b0;
            end
            if (u_ok) begin
              tx <= u_tn;
              sx <= u_sn;
            end else begin
              state <= ST_ROW;
            end
          end
        end
        ST_ROW: begin
          if (u_ok) begin
            ty    <= u_tn;
            sy    <= u_sn;
            tx    <= tx0;
            sx    <= sx0;
            state <= ST_PIX;
          end else begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!pend_v) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_v <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/clipped_tile_blitter.sv]
// ----------------------------------------------------------------------------
// clipped_tile_blitter
// Turns one-bit tiles into clipped framebuffer pixel writes, row by row.
//
// Channel  Direction  Handshake              Carries
// in       input      in_valid / in_stall    req_type x_pos y_pos tile_size tile_rows
// out      output     out_valid / out_stall  pixel_x pixel_y pixel_on last_write
// cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// A tile holds in_stall high while the single step unit walks its visible rows
// and columns, emitting one pixel per cycle while the output register is free,
// with a separate row-advance state between rows.
// The next item is taken only while the block is idle.
// The block takes no new item until the current tile is done.
// A stalled output register holds the walk at the next pixel write.
// Reset restores the frame size to 128 by 64 and drops any tile in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_tile_blitter #(
  parameter int unsigned TILE_MAX_SIDE = ctb_pkg::TILE_MAX_SIDE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        req_type,
  input  wire logic [ctb_pkg::COORD_W-1:0]       x_pos,
  input  wire logic [ctb_pkg::COORD_W-1:0]       y_pos,
  input  wire logic [7:0]                        tile_size,
  input  wire logic [ctb_pkg::ROWS_W-1:0]        tile_rows,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [ctb_pkg::COORD_W-1:0]       pixel_x,
  output logic      [ctb_pkg::COORD_W-1:0]       pixel_y,
  output logic                                   pixel_on,
  output logic                                   last_write,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ctb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ctb_pkg::COORD_W-1:0]       cfg_data
);

  logic [ctb_pkg::COORD_W-1:0] frame_width, frame_height;
  logic                        busy, push, out_free, start;
  ctb_pkg::pix_t               pix;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;
  assign start     = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  ctb_seq #(
    .TILE_MAX_SIDE (TILE_MAX_SIDE)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_type     (req_type),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .tile_size    (tile_size),
    .tile_rows    (tile_rows),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .out_free     (out_free),
    .busy         (busy),
    .push         (push),
    .pix          (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ctb_pkg::FRAME_WIDTH_RST;
      frame_height <= ctb_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ctb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        ctb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
          frame_width <= frame_width;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pixel_x    <= pix.x;
      pixel_y    <= pix.y;
      pixel_on   <= pix.on;
      last_write <= pix.last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(push && out_valid && out_stall))
    else $error("pixel write pushed into a full output register");

  a_reserved_dropped: assert property (@(posedge clk) disable iff (rst)
    (start && req_type == ctb_pkg::MODE_RESERVED) |=> !in_stall)
    else $error("reserved mode item did not leave the block idle");

  a_item_starts: assert property (@(posedge clk) disable iff (rst)
    (start && req_type != ctb_pkg::MODE_RESERVED) |=> in_stall)
    else $error("accepted tile did not start a walk");

  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !push)
    else $error("pixel write emitted while idle");

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped tile blitter testbench
// Sends one-bit tiles through the valid/stall input channel and checks every
// pixel write against a behavioral expansion of the tile, clipped to the frame
// size in force (reset or written through the configuration channel). A short
// table of directed tiles comes first; random tiles then follow over several
// frame sizes, with bursty input traffic and a changing output stall pattern.
// ----------------------------------------------------------------------------

module testbench;
  import ctb_pkg::*;

  localparam int TILE_SIDE = TILE_MAX_SIDE_DEF;
  localparam int SETTLE_CYCLES = 100;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_PHASES = 6;
  localparam int PHASE_WIDTH [N_PHASES] = '{255, 1, 13, 0, -1, 100};
  localparam int PHASE_HEIGHT [N_PHASES] = '{255, 1, 9, 255, -1, 50};
  localparam int PHASE_TILES [N_PHASES] = '{20, 10, 25, 10, 20, 15};

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  size;
    logic [63:0] rows;
  } tile_t;

  typedef enum logic [1:0] {EXP_EXPAND, EXP_NONE, EXP_ONE} exp_kind_t;

  typedef struct packed {
    tile_t     tile;
    exp_kind_t kind;
    pix_t      single;
  } dir_row_t;

  localparam int N_DIRECTED = 24;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{MODE_TRANSPARENT, 8'd0, 8'd0, 8'h00, 64'h80}, EXP_ONE, '{8'd0, 8'd0, 1'b1, 1'b1}},
    '{'{MODE_ERASE, 8'd0, 8'd0, 8'h00, 64'h80}, EXP_ONE, '{8'd0, 8'd0, 1'b0, 1'b1}},
    '{'{MODE_FULL, 8'd0, 8'd0, 8'h00, 64'h00}, EXP_ONE, '{8'd0, 8'd0, 1'b0, 1'b1}},
    '{'{MODE_TRANSPARENT, 8'd0, 8'd0, 8'h00, 64'h00}, EXP_NONE, '0},
    '{'{MODE_RESERVED, 8'd0, 8'd0, 8'h77, 64'hFFFF_FFFF_FFFF_FFFF}, EXP_NONE, '0},
    '{'{MODE_FULL, 8'd0, 8'd0, 8'h77, 64'hFFFF_FFFF_FFFF_FFFF}, EXP_EXPAND, '0},
    '{'{MODE_TRANSPARENT, 8'd5, 8'd3, 8'h77, 64'hAA55_AA55_AA55_AA55}, EXP_EXPAND, '0},
    '{'{MODE_ERASE, 8'd10, 8'd10, 8'h77, 64'h0123_4567_89AB_CDEF}, EXP_EXPAND, '0},
    '{'{MODE_FULL, 8'hFD, 8'd0, 8'h77, 64'hF0F0_F0F0_0F0F_0F0F}, EXP_EXPAND, '0},
    '{'{MODE_TRANSPARENT, 8'd0, 8'hFB, 8'h77, 64'hFFFF_FFFF_FFFF_FFFF}, EXP_EXPAND, '0},
    '{'{MODE_FULL, 8'h80, 8'd0, 8'h77, 64'hFFFF_FFFF_FFFF_FFFF}, EXP_NONE, '0},
    '{'{MODE_FULL, 8'h7F, 8'h7F, 8'h77, 64'hFFFF_FFFF_FFFF_FFFF}, EXP_NONE, '0},
    '{'{MODE_TRANSPARENT, 8'd127, 8'd63, 8'h00, 64'h80}, EXP_ONE,
      '{8'd127, 8'd63, 1'b1, 1'b1}},
    '{'{MODE_FULL, 8'd120, 8'd60, 8'h77, 64'h8142_2418_1824_4281}, EXP_EXPAND, '0},
    '{'{MODE_FULL, 8'd30, 8'd20, 8'hFF, 64'h00FF_00FF_00FF_00FF}, EXP_EXPAND, '0},
    '{'{MODE_TRANSPARENT, 8'd2, 8'd2, 8'h88, 64'h80}, EXP_ONE, '{8'd2, 8'd2, 1'b1, 1'b1}},
    '{'{MODE_TRANSPARENT, 8'hF8, 8'd0, 8'h77, 64'hFFFF_FFFF_FFFF_FFFF}, EXP_NONE, '0},
    '{'{MODE_TRANSPARENT, 8'hF9, 8'hF9, 8'h77, 64'hFFFF_FFFF_FFFF_FFFF}, EXP_ONE,
      '{8'd0, 8'd0, 1'b1, 1'b1}},
    '{'{MODE_ERASE, 8'hFF, 8'hFF, 8'h77, 64'hFFFF_FFFF_FFFF_FFFF}, EXP_EXPAND, '0},
    '{'{MODE_FULL, 8'd60, 8'd30, 8'h30, 64'h0000_0000_0000_00A0}, EXP_EXPAND, '0},
    '{'{MODE_TRANSPARENT, 8'd0, 8'd0, 8'h07, 64'hFFFF_FFFF_FFFF_FFFF}, EXP_EXPAND, '0},
    '{'{MODE_FULL, 8'h80, 8'h80, 8'h77, 64'h00}, EXP_NONE, '0},
    '{'{MODE_ERASE, 8'd127, 8'd0, 8'h70, 64'hFF}, EXP_ONE, '{8'd127, 8'd0, 1'b0, 1'b1}},
    '{'{MODE_TRANSPARENT, 8'd50, 8'd40, 8'h77, 64'h00}, EXP_NONE, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] req_type;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [7:0] tile_size;
  logic [63:0] tile_rows;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic pixel_on;
  logic last_write;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  logic [7:0] fb_width;
  logic [7:0] fb_height;
  pix_t pending_writes[$];
  int burst_left = 0;
  int mismatch_count = 0;
  int writes_checked = 0;
  int tiles_sent = 0;
  int reserved_sent = 0;
  int quiet_cycles = 0;
  int stall_style = 0;
  int stall_left = 0;
  int stall_tick = 0;

  always #5 clk = ~clk;

  clipped_tile_blitter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .x_pos(x_pos),
    .y_pos(y_pos),
    .tile_size(tile_size),
    .tile_rows(tile_rows),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pixel_on(pixel_on),
    .last_write(last_write),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic void expand_tile(input tile_t t);
    pix_t writes[$];
    pix_t p;
    int xs, ys, w, h, tx, ty, sx, sy;
    logic [7:0] row_bits;
    logic bit_set;
    if (t.mode == MODE_RESERVED) return;
    xs = int'($signed(t.x));
    ys = int'($signed(t.y));
    w = int'(t.size[6:4]) + 1;
    h = int'(t.size[2:0]) + 1;
    if (w > TILE_SIDE) w = TILE_SIDE;
    if (h > TILE_SIDE) h = TILE_SIDE;
    for (ty = (ys < 0) ? -ys : 0; ty < h; ty++) begin
      sy = ys + ty;
      if (sy < 0 || sy >= int'(fb_height)) break;
      row_bits = t.rows[8*ty +: 8];
      for (tx = (xs < 0) ? -xs : 0; tx < w; tx++) begin
        sx = xs + tx;
        if (sx < 0 || sx >= int'(fb_width)) break;
        bit_set = row_bits[7-tx];
        if (bit_set || t.mode == MODE_FULL) begin
          p.x = sx[7:0];
          p.y = sy[7:0];
          p.on = bit_set && (t.mode != MODE_ERASE);
          p.last = 1'b0;
          writes.push_back(p);
        end
      end
    end
    if (writes.size() > 0) writes[writes.size()-1].last = 1'b1;
    foreach (writes[i]) pending_writes.push_back(writes[i]);
  endfunction

  function automatic logic [7:0] pick_coord(input int lim);
    int v;
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: v = int'($urandom_range(0, 15)) - 8;
      2: v = lim - int'($urandom_range(1, 10));
      default: v = int'($urandom_range(0, (lim > 127) ? 127 : lim));
    endcase
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[7:0];
  endfunction

  function automatic tile_t random_tile();
    tile_t t;
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) t.mode = MODE_RESERVED;
    else t.mode = 2'($urandom_range(0, 2));
    t.x = pick_coord(int'(fb_width));
    t.y = pick_coord(int'(fb_height));
    t.size = 8'($urandom);
    case ($urandom_range(0, 2))
      0: t.rows = a;
      1: t.rows = a & b;
      default: t.rows = a | b;
    endcase
    return t;
  endfunction

  // Starts and ends at a falling edge; valid stays high within a burst.
  task automatic send_tile(input tile_t t, input exp_kind_t kind, input pix_t single);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: gap = 0;
        4, 5: gap = $urandom_range(1, 4);
        6: gap = $urandom_range(5, 20);
        default: gap = $urandom_range(30, 90);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    req_type <= t.mode;
    x_pos <= t.x;
    y_pos <= t.y;
    tile_size <= t.size;
    tile_rows <= t.rows;
    do @(posedge clk); while (in_stall);
    case (kind)
      EXP_EXPAND: expand_tile(t);
      EXP_ONE: pending_writes.push_back(single);
      default: ;
    endcase
    if (t.mode == MODE_RESERVED) reserved_sent++;
    else tiles_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_frame(input logic [7:0] w, input logic [7:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    fb_width = w;
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    fb_height = h;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input pix_t want, input pix_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected x=%0d y=%0d on=%0b last=%0b, got x=%0d y=%0d on=%0b last=%0b",
               $realtime, what, want.x, want.y, want.on, want.last,
               got.x, got.y, got.on, got.last);
  endtask

  always @(posedge clk) begin : check_writes
    pix_t want;
    pix_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{pixel_x, pixel_y, pixel_on, last_write};
      writes_checked++;
      if (pending_writes.size() == 0) begin
        note_mismatch("unexpected pixel write", '0, got);
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) note_mismatch("pixel write differs", want, got);
      end
    end
  end

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((stall_tick % 7) < 3);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timed out with %0d pixel writes still expected.", pending_writes.size());
      $display("clipped_tile_blitter: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    tile_t t;
    int sent;
    int w, h;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = MODE_TRANSPARENT;
    x_pos = '0;
    y_pos = '0;
    tile_size = '0;
    tile_rows = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    fb_width = FRAME_WIDTH_RST;
    fb_height = FRAME_HEIGHT_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_tile(DIRECTED[i].tile, DIRECTED[i].kind, DIRECTED[i].single);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_and_settle();
      w = (PHASE_WIDTH[ph] < 0) ? $urandom_range(1, 255) : PHASE_WIDTH[ph];
      h = (PHASE_HEIGHT[ph] < 0) ? $urandom_range(1, 255) : PHASE_HEIGHT[ph];
      write_frame(w[7:0], h[7:0]);
      sent = 0;
      while (sent < PHASE_TILES[ph]) begin
        t = random_tile();
        send_tile(t, EXP_EXPAND, '0);
        if (t.mode != MODE_RESERVED) sent++;
      end
    end
    drain_and_settle();

    $display("Checked %0d pixel writes from %0d tiles (plus %0d reserved-mode items)",
             writes_checked, tiles_sent, reserved_sent);
    $display("over the reset frame and %0d written frame sizes; %0d mismatches.",
             N_PHASES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("clipped_tile_blitter: match");
    end else begin
      $display("clipped_tile_blitter: mismatch");
    end
    $finish;
  end

endmodule
